// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the window statistics rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/aws_pkg.sv -----
// types and constants for the converter window statistics block
// used by aws_ctrl, aws_dp and adc_window_statistics
package aws_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int MAX_WINDOW = 1024;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int VREF_W     = 16;
    localparam int FS_W       = 10;
    localparam int BAR_W      = 8;
    localparam int MV_W       = 16;

    localparam int DIV_W      = SAMPLE_W + VREF_W;
    localparam int DVS_W      = CNT_W;
    localparam int STEP_W     = $clog2(DIV_W);

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VREF_MV    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_SCALE = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BAR_WIDTH  = 2'd3;

    localparam logic [CNT_W-1:0]  WINDOW_LEN_RST = 11'd50;
    localparam logic [VREF_W-1:0] VREF_RST       = 16'd3300;
    localparam logic [FS_W-1:0]   FS_RST         = 10'd1023;
    localparam logic [BAR_W-1:0]  BAR_RST        = 8'd40;

    typedef logic [1:0] div_src_t;
    localparam div_src_t SRC_AVG = 2'd0;
    localparam div_src_t SRC_MV  = 2'd1;
    localparam div_src_t SRC_BAR = 2'd2;

    typedef struct packed {
        logic     acc;
        logic     div_load;
        div_src_t div_src;
        logic     div_step;
        logic     cap_avg;
        logic     cap_mv;
        logic     cap_bar;
        logic     out_load;
    } aws_cmd_t;

    typedef struct packed {
        logic close_hit;
        logic out_free;
    } aws_sts_t;

endpackage

// ----- hw/rtl/aws_ctrl.sv -----
// sequencer for the window statistics block: sample accept, division steps and result load
// depends on aws_pkg and assert_macros.svh
`include "assert_macros.svh"

module aws_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aws_pkg::aws_sts_t sts,
    output aws_pkg::aws_cmd_t cmd
);
    import aws_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LD_AVG  = 3'd1;
    localparam logic [2:0] S_DIV_AVG = 3'd2;
    localparam logic [2:0] S_LD_MV   = 3'd3;
    localparam logic [2:0] S_DIV_MV  = 3'd4;
    localparam logic [2:0] S_LD_BAR  = 3'd5;
    localparam logic [2:0] S_DIV_BAR = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              last_step;

    assign last_step = (step_reg == STEP_LAST);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.div_src  = SRC_AVG;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.acc = 1'b1;
                    if (sts.close_hit)
                    begin
                        state_next = S_LD_AVG;
                    end
                end
            end
            S_LD_AVG:
            begin
                cmd.div_load = 1'b1;
                cmd.div_src  = SRC_AVG;
                step_next    = '0;
                state_next   = S_DIV_AVG;
            end
            S_DIV_AVG:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (last_step)
                begin
                    cmd.cap_avg = 1'b1;
                    state_next  = S_LD_MV;
                end
            end
            S_LD_MV:
            begin
                cmd.div_load = 1'b1;
                cmd.div_src  = SRC_MV;
                step_next    = '0;
                state_next   = S_DIV_MV;
            end
            S_DIV_MV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (last_step)
                begin
                    cmd.cap_mv = 1'b1;
                    state_next = S_LD_BAR;
                end
            end
            S_LD_BAR:
            begin
                cmd.div_load = 1'b1;
                cmd.div_src  = SRC_BAR;
                step_next    = '0;
                state_next   = S_DIV_BAR;
            end
            S_DIV_BAR:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (last_step)
                begin
                    cmd.cap_bar = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `AWS_ASSERT_NEXT(a_close_starts_avg, cmd.acc && sts.close_hit, state_reg == S_LD_AVG, "window close did not start the average")
    `AWS_ASSERT_NOW(a_load_needs_room, cmd.out_load, sts.out_free, "result loaded over a pending transfer")
    `AWS_ASSERT_NOW(a_step_in_range, cmd.div_step, step_reg <= STEP_LAST, "division step counter overran")

endmodule

// ----- hw/rtl/aws_dp.sv -----
// datapath: config registers, running min/max/sum/count, shared divider, result register
// depends on aws_pkg and assert_macros.svh
`include "assert_macros.svh"

module aws_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [aws_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [aws_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [aws_pkg::SAMPLE_W-1:0]       sample,
    input  aws_pkg::aws_cmd_t                  cmd,
    output aws_pkg::aws_sts_t                  sts,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [aws_pkg::OUT_DATA_W-1:0]     out_data
);
    import aws_pkg::*;

    logic [CNT_W-1:0]    window_len_reg;
    logic [VREF_W-1:0]   vref_reg;
    logic [FS_W-1:0]     fs_reg;
    logic [BAR_W-1:0]    bar_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic [DIV_W-1:0]    quo_reg;
    logic [DIV_W-1:0]    quo_next;
    logic [DVS_W-1:0]    rem_reg;
    logic [DVS_W-1:0]    rem_next;
    logic [DVS_W-1:0]    dvs_reg;
    logic [DVS_W:0]      shifted;
    logic                ge;

    logic [SAMPLE_W-1:0] avg_reg;
    logic [MV_W-1:0]     mv_reg;
    logic [BAR_W-1:0]    bar_len_reg;

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] o_min_reg;
    logic [SAMPLE_W-1:0] o_max_reg;
    logic [SAMPLE_W-1:0] o_avg_reg;
    logic [MV_W-1:0]     o_mv_reg;
    logic [SAMPLE_W-1:0] o_p2p_reg;
    logic [BAR_W-1:0]    o_bar_reg;

    logic [CNT_W-1:0]    count_inc;
    logic [CNT_W-1:0]    len_eff;
    logic [FS_W-1:0]     fs_eff;
    logic [VREF_W-1:0]   mul_b;
    logic [DIV_W-1:0]    product;
    logic [DIV_W-1:0]    load_dividend;
    logic [DVS_W-1:0]    load_divisor;

    // window length and full scale guards
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (window_len_reg > CNT_W'(MAX_WINDOW))
        begin
            len_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = window_len_reg;
        end
    end

    assign fs_eff        = (fs_reg == '0) ? FS_W'(1) : fs_reg;
    assign count_inc     = count_reg + 1'b1;
    assign sts.close_hit = (count_inc >= len_eff);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // one shared multiplier for both scalings
    assign mul_b   = (cmd.div_src == SRC_MV) ? vref_reg : VREF_W'(bar_reg);
    assign product = DIV_W'(avg_reg) * DIV_W'(mul_b);

    always_comb
    begin
        case (cmd.div_src)
            SRC_AVG:
            begin
                load_dividend = DIV_W'(sum_reg);
                load_divisor  = count_reg;
            end
            SRC_MV, SRC_BAR:
            begin
                load_dividend = product;
                load_divisor  = DVS_W'(fs_eff);
            end
            default:
            begin
                load_dividend = '0;
                load_divisor  = DVS_W'(1);
            end
        endcase
    end

    // restoring divider, one quotient bit per step
    assign shifted  = {rem_reg, quo_reg[DIV_W-1]};
    assign ge       = (shifted >= {1'b0, dvs_reg});
    assign rem_next = ge ? DVS_W'(shifted - {1'b0, dvs_reg}) : shifted[DVS_W-1:0];
    assign quo_next = {quo_reg[DIV_W-2:0], ge};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg <= load_dividend;
            rem_reg <= '0;
            dvs_reg <= load_divisor;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.cap_avg)
        begin
            avg_reg <= quo_next[SAMPLE_W-1:0];
        end
        if (cmd.cap_mv)
        begin
            mv_reg <= (|quo_next[DIV_W-1:MV_W]) ? '1 : quo_next[MV_W-1:0];
        end
        if (cmd.cap_bar)
        begin
            bar_len_reg <= (quo_next > DIV_W'(bar_reg)) ? bar_reg : quo_next[BAR_W-1:0];
        end
        if (cmd.out_load)
        begin
            o_min_reg <= min_reg;
            o_max_reg <= max_reg;
            o_avg_reg <= avg_reg;
            o_mv_reg  <= mv_reg;
            o_p2p_reg <= max_reg - min_reg;
            o_bar_reg <= bar_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RST;
            vref_reg       <= VREF_RST;
            fs_reg         <= FS_RST;
            bar_reg        <= BAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WINDOW_LEN: window_len_reg <= cfg_wdata[CNT_W-1:0];
                REG_VREF_MV:    vref_reg       <= cfg_wdata[VREF_W-1:0];
                REG_FULL_SCALE: fs_reg         <= cfg_wdata[FS_W-1:0];
                REG_BAR_WIDTH:  bar_reg        <= cfg_wdata[BAR_W-1:0];
                default:        ;
            endcase
        end
    end

    // running window state, restarted when the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.out_load)
        begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.acc)
        begin
            count_reg <= count_inc;
            sum_reg   <= sum_reg + SUM_W'(sample);
            if (sample < min_reg)
            begin
                min_reg <= sample;
            end
            if (sample > max_reg)
            begin
                max_reg <= sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {o_bar_reg, o_p2p_reg, o_mv_reg, o_avg_reg, o_max_reg, o_min_reg};

    `AWS_ASSERT_NOW(a_min_below_max, count_reg != '0, min_reg <= max_reg, "running min above running max")
    `AWS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_WINDOW), "sample count beyond window limit")
    `AWS_ASSERT_NEXT(a_restart, cmd.out_load, (count_reg == '0) && (sum_reg == '0) && out_valid_reg, "window not restarted on result load")

endmodule

// ----- hw/rtl/adc_window_statistics.sv -----
// top level of the converter window statistics block
// depends on aws_pkg, aws_ctrl and aws_dp
//
// channel  dir  signals                      contents
// s_axis   in   tvalid tready tdata[15:0]    one converter sample
// m_axis   out  tvalid tready tdata[63:0]    one statistics result per window
// cfg      in   cfg_we cfg_addr cfg_wdata    window_len, vref_mv, full_scale, bar scale
//
// a sample that does not close its window leaves the sequencer idle and ready for the next one
// a closing sample starts three passes of the one-bit-per-cycle restoring divider (average,
// millivolts, bar length), then the result is loaded into the output register
// input is held off during those passes and while a finished result waits for a free output
// rst_n clears the control state and restores the register reset values
module adc_window_statistics (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [aws_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [aws_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [9:0] sample, [15:10] zero
    input  logic [aws_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [9:0] window_min, [19:10] window_max, [29:20] window_avg,
    // [45:30] avg_millivolts, [55:46] peak_to_peak, [63:56] bar_length
    output logic [aws_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import aws_pkg::*;

    aws_cmd_t cmd;
    aws_sts_t sts;

    aws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aws_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- sim/adc_window_statistics_tb.sv -----
// self-checking testbench for adc_window_statistics: streams converter samples,
// predicts each window's min, max, average, millivolts, peak-to-peak and bar length
// depends on aws_pkg and the adc_window_statistics rtl
module adc_window_statistics_tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int WINDOW_CAP    = aws_pkg::MAX_WINDOW;

    // lowest field in the lowest bits, as on m_axis_tdata
    typedef struct packed {
        logic [7:0]  bar_length;
        logic [9:0]  peak_to_peak;
        logic [15:0] avg_millivolts;
        logic [9:0]  window_avg;
        logic [9:0]  window_max;
        logic [9:0]  window_min;
    } win_stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [aws_pkg::CFG_ADDR_W-1:0] cfg_addr = aws_pkg::REG_WINDOW_LEN;
    logic [aws_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [aws_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b1;
    logic [aws_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // predictor copy of the registers
    logic [10:0] set_window_len = 11'd50;
    logic [15:0] set_vref_mv    = 16'd3300;
    logic [9:0]  set_full_scale = 10'd1023;
    logic [7:0]  set_bar_span   = 8'd40;

    // predictor copy of the running window
    int acc_count = 0;
    int acc_min   = 1023;
    int acc_max   = 0;
    int acc_sum   = 0;

    win_stats_t pending_stats[$];
    win_stats_t want_stats;
    win_stats_t got_stats;

    bit src_idle  = 1'b0;
    bit sink_idle = 1'b0;
    int band_lo   = 0;
    int band_hi   = 1023;

    int fail_count      = 0;
    int samples_sent    = 0;
    int windows_checked = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;

    adc_window_statistics uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("adc_window_statistics_tb: FAIL");
            $finish;
        end
    end

    // adds one sample to the running window, returns 1 when the window closes
    function automatic bit fold_sample(input logic [9:0] s, output win_stats_t r);
        int eff_len;
        int fs;
        int avg;
        longint unsigned mv;
        longint unsigned bar;
        r = '0;
        if (s < acc_min)
            acc_min = s;
        if (s > acc_max)
            acc_max = s;
        acc_sum += s;
        acc_count++;
        eff_len = set_window_len;
        if (eff_len == 0)
            eff_len = 1;
        if (eff_len > WINDOW_CAP)
            eff_len = WINDOW_CAP;
        if (acc_count < eff_len)
            return 1'b0;
        fs  = (set_full_scale == 0) ? 1 : set_full_scale;
        avg = acc_sum / acc_count;
        mv  = (longint'(avg) * set_vref_mv) / fs;
        if (mv > 65535)
            mv = 65535;
        bar = (longint'(avg) * set_bar_span) / fs;
        if (bar > set_bar_span)
            bar = set_bar_span;
        r.window_min     = acc_min[9:0];
        r.window_max     = acc_max[9:0];
        r.window_avg     = avg[9:0];
        r.avg_millivolts = mv[15:0];
        r.peak_to_peak   = 10'(acc_max - acc_min);
        r.bar_length     = bar[7:0];
        acc_count = 0;
        acc_min   = 1023;
        acc_max   = 0;
        acc_sum   = 0;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_stats.size() == 0)
            begin
                $error("result transfer with no window pending: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want_stats = pending_stats.pop_front();
                got_stats  = win_stats_t'(m_axis_tdata);
                check_field("window_min", want_stats.window_min, got_stats.window_min);
                check_field("window_max", want_stats.window_max, got_stats.window_max);
                check_field("window_avg", want_stats.window_avg, got_stats.window_avg);
                check_field("avg_millivolts", want_stats.avg_millivolts,
                            got_stats.avg_millivolts);
                check_field("peak_to_peak", want_stats.peak_to_peak, got_stats.peak_to_peak);
                check_field("bar_length", want_stats.bar_length, got_stats.bar_length);
                windows_checked++;
            end
        end
    end

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (sink_idle && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    task automatic send_sample(input logic [9:0] s);
        win_stats_t r;
        if (src_idle && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 16)) @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'b0, s};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (fold_sample(s, r))
            pending_stats.push_back(r);
        samples_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // all pending windows transferred, then a settling wait of SETTLE_CYCLES
    task automatic wait_drained();
        while (pending_stats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [aws_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [15:0] data);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (addr)
            aws_pkg::REG_WINDOW_LEN: set_window_len = data[10:0];
            aws_pkg::REG_VREF_MV:    set_vref_mv    = data;
            aws_pkg::REG_FULL_SCALE: set_full_scale = data[9:0];
            aws_pkg::REG_BAR_WIDTH:  set_bar_span   = data[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_config(input logic [15:0] wlen, input logic [15:0] vref,
                                input logic [15:0] fs, input logic [15:0] bar);
        wait_drained();
        write_reg(aws_pkg::REG_WINDOW_LEN, wlen);
        write_reg(aws_pkg::REG_VREF_MV, vref);
        write_reg(aws_pkg::REG_FULL_SCALE, fs);
        write_reg(aws_pkg::REG_BAR_WIDTH, bar);
    endtask

    function automatic logic [9:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 10'd0;
            1: return 10'd1023;
            2, 3, 4: return 10'($urandom_range(0, 1023));
            default: return 10'($urandom_range(band_lo, band_hi));
        endcase
    endfunction

    function automatic logic [15:0] pick_window_len();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'($urandom_range(41, 120));
            2, 3: return 16'($urandom_range(7, 40));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] pick_vref();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd3300;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_full_scale();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 15));
            2: return 16'd1023;
            default: return 16'($urandom_range(1, 1023));
        endcase
    endfunction

    function automatic logic [15:0] pick_bar_span();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd255;
            default: return 16'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic pick_band();
        band_lo = $urandom_range(0, 1023);
        band_hi = band_lo + $urandom_range(0, 64);
        if (band_hi > 1023)
            band_hi = 1023;
    endtask

    // reset register values: window of 50, 3300 mV, full scale 1023, bar of 40
    task automatic test_reset_defaults();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        pick_band();
        repeat (50) send_sample(pick_sample());
    endtask

    task automatic test_directed_corners();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        // zero window length acts as one, zero full scale acts as one
        apply_config(16'd0, 16'hFFFF, 16'hFC00, 16'd255);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd1);
        apply_config(16'd1, 16'd0, 16'd1023, 16'd0);
        send_sample(10'd1023);
        send_sample(10'd0);
        // average far above full scale: millivolts saturate, bar clamps
        apply_config(16'd1, 16'hFFFF, 16'd1, 16'd255);
        send_sample(10'd1);
        send_sample(10'd1023);
        send_sample(10'd0);
        apply_config(16'd2, 16'd3300, 16'd1023, 16'd40);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd0);
        send_sample(10'd5);
        send_sample(10'd6);
        // longest window, then shortened below the count already taken
        apply_config(16'd1024, 16'd5000, 16'd700, 16'd100);
        send_sample(10'd100);
        send_sample(10'd900);
        send_sample(10'd513);
        send_sample(10'd2);
        send_sample(10'd1021);
        apply_config(16'd3, 16'd5000, 16'd700, 16'd100);
        send_sample(10'd7);
    endtask

    // register value above the window limit, the window closes at the limit
    task automatic test_max_window();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        apply_config(16'hFFFF, 16'd3300, 16'd1000, 16'd200);
        repeat (WINDOW_CAP) send_sample(10'($urandom_range(0, 1023)));
    endtask

    task automatic test_random_windows();
        repeat (16)
        begin
            apply_config(pick_window_len(), pick_vref(), pick_full_scale(), pick_bar_span());
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            pick_band();
            repeat ($urandom_range(4, 12)) send_sample(pick_sample());
        end
    endtask

    task automatic test_full_rate();
        apply_config(16'($urandom_range(1, 4)), pick_vref(), pick_full_scale(),
                     pick_bar_span());
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        pick_band();
        repeat (40) send_sample(pick_sample());
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_directed_corners();
        test_max_window();
        test_random_windows();
        test_full_rate();

        wait_drained();
        $display("sent %0d samples over %0d register writes, checked %0d windows",
                 samples_sent, reg_writes, windows_checked);
        if (fail_count == 0)
            $display("adc_window_statistics_tb: PASS");
        else
            $display("adc_window_statistics_tb: FAIL");
        $finish;
    end

endmodule
